>>> rtl/factor_sum_out_variable_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for factor_sum_out_variable
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FACTOR_SUM_OUT_VARIABLE_MACROS_SVH
`define FACTOR_SUM_OUT_VARIABLE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define FSOV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsov assertion failed");

// The consequent holds in the cycle after the antecedent.
`define FSOV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsov assertion failed");

`endif

>>> rtl/fsov_pkg.sv
// ----------------------------------------------------------------------------
// fsov_pkg
// Types and constants shared by the factor sum-out blocks.
// ----------------------------------------------------------------------------
package fsov_pkg;

  localparam int ENTRY_W   = 32;
  localparam int RINDEX_W  = 12;
  localparam int DIGIT_W   = 4;
  localparam int IDX_W_MAX = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_VARS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CARDS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_POS  = 2'd2;

  typedef struct packed {
    logic                cmd;
    logic [ENTRY_W-1:0]  entry_value;
    logic [RINDEX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [RINDEX_W-1:0] result_index;
    logic [ENTRY_W-1:0]  result_value;
    logic                overflow;
    logic                table_done;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  num_vars;
    logic [31:0] cards;
    logic [3:0]  sum_pos;
  } cfg_t;

  typedef struct packed {
    logic                 cmd;
    logic [ENTRY_W-1:0]   value;
    logic [IDX_W_MAX-1:0] idx;
    logic                 wr_new;
    logic                 first;
    logic                 done;
  } mid_item_t;

endpackage

>>> rtl/fsov_fifo.sv
// ----------------------------------------------------------------------------
// fsov_fifo
// Small synchronous queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module fsov_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  output logic  full,
  input  item_t data_in,
  input  logic  pop,
  output logic  empty,
  output item_t data_out
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t           mem_r [DEPTH];
  logic [PW-1:0]   wp_r;
  logic [PW-1:0]   rp_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= data_in;
    end
  end

endmodule

>>> rtl/fsov_front.sv
// ----------------------------------------------------------------------------
// fsov_front
// Accepts items, runs the assignment digit counter and computes the result
// index through a pipeline of mixed-radix Horner steps, one scope position
// per stage, reduced modulo the store depth at every step.
// ----------------------------------------------------------------------------
module fsov_front #(
  parameter int MAX_VARS    = 8,
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fsov_pkg::cfg_t      cfg,
  input  logic                in_push,
  input  fsov_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                mq_push,
  output fsov_pkg::mid_item_t mq_item,
  input  logic                mq_full
);

  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int NSTG    = (MAX_VARS < 3) ? 3 : MAX_VARS;
  localparam int CW      = 5;
  localparam int TW      = AW + CW;
  localparam int RD_NIBS = 3;
  localparam bit D_POW2  = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

  typedef struct packed {
    logic [CW-1:0]                c;
    logic [fsov_pkg::DIGIT_W-1:0] d;
  } cd_t;

  logic [fsov_pkg::DIGIT_W-1:0] dig_r   [NSTG];
  logic [fsov_pkg::DIGIT_W-1:0] dig_nxt [NSTG];
  logic [NSTG:0]                v_r;
  fsov_pkg::mid_item_t          meta_r  [NSTG+1];
  logic [AW-1:0]                acc_r   [NSTG+1];
  cd_t                          cd_r    [NSTG][NSTG];
  cd_t                          cd_nxt  [NSTG];
  fsov_pkg::mid_item_t          meta_nxt;
  logic [3:0]                   n_act;
  logic                         absent;
  logic                         f_adv;
  logic                         accept;

  function automatic logic [AW-1:0] idx_step(input logic [AW-1:0] acc, input cd_t cd);
    logic [TW-1:0] t;
    t = TW'(acc) * TW'(cd.c) + TW'(cd.d);
    if (!D_POW2) begin
      for (int q = 3; q >= 0; q--) begin
        if (t >= (TW'(TABLE_DEPTH) << q)) begin
          t = t - (TW'(TABLE_DEPTH) << q);
        end
      end
    end
    return t[AW-1:0];
  endfunction

  assign f_adv   = !mq_full;
  assign in_full = mq_full;
  assign accept  = in_push && f_adv;

  always_comb begin
    logic       carry;
    logic       first;
    logic [3:0] sel_dig;
    logic [3:0] cm1;
    if (cfg.num_vars == 4'd0) begin
      n_act = 4'd1;
    end else if (cfg.num_vars > 4'(MAX_VARS)) begin
      n_act = 4'(MAX_VARS);
    end else begin
      n_act = cfg.num_vars;
    end
    absent  = (cfg.sum_pos >= n_act);
    carry   = 1'b1;
    first   = 1'b1;
    sel_dig = '0;
    for (int k = NSTG - 1; k >= 0; k--) begin
      cm1        = cfg.cards[4*k +: 4];
      dig_nxt[k] = dig_r[k];
      if (4'(k) < n_act) begin
        if (dig_r[k] != '0) begin
          first = 1'b0;
        end
        if (4'(k) == cfg.sum_pos) begin
          sel_dig = dig_r[k];
        end
        if (carry) begin
          if (dig_r[k] < cm1) begin
            dig_nxt[k] = dig_r[k] + 1'b1;
            carry      = 1'b0;
          end else begin
            dig_nxt[k] = '0;
          end
        end
      end
      cd_nxt[k].c = CW'(1);
      cd_nxt[k].d = '0;
      if (in_item.cmd == fsov_pkg::CMD_READ) begin
        if (k < RD_NIBS) begin
          cd_nxt[k].c = CW'(16);
          cd_nxt[k].d = 4'(in_item.read_index >> (4 * (RD_NIBS - 1 - k)));
        end
      end else if ((4'(k) < n_act) && !(!absent && (4'(k) == cfg.sum_pos))) begin
        cd_nxt[k].c = CW'(cm1) + CW'(1);
        cd_nxt[k].d = dig_r[k];
      end
    end
    meta_nxt.cmd    = in_item.cmd;
    meta_nxt.value  = in_item.entry_value;
    meta_nxt.idx    = '0;
    meta_nxt.wr_new = absent || (sel_dig == '0);
    meta_nxt.first  = first;
    meta_nxt.done   = carry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      for (int k = 0; k < NSTG; k++) begin
        dig_r[k] <= '0;
      end
    end else begin
      if (accept && (in_item.cmd == fsov_pkg::CMD_ACCUM)) begin
        dig_r <= dig_nxt;
      end
      if (f_adv) begin
        v_r <= {v_r[NSTG-1:0], accept};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f_adv) begin
      meta_r[0] <= meta_nxt;
      acc_r[0]  <= '0;
      cd_r[0]   <= cd_nxt;
      for (int s = 0; s < NSTG; s++) begin
        meta_r[s+1] <= meta_r[s];
        acc_r[s+1]  <= idx_step(acc_r[s], cd_r[s][s]);
      end
      for (int s = 0; s < NSTG - 1; s++) begin
        cd_r[s+1] <= cd_r[s];
      end
    end
  end

  always_comb begin
    mq_item     = meta_r[NSTG];
    mq_item.idx = fsov_pkg::IDX_W_MAX'(acc_r[NSTG]);
  end

  assign mq_push = v_r[NSTG] && f_adv;

endmodule

>>> rtl/fsov_back.sv
// ----------------------------------------------------------------------------
// fsov_back
// Carries out store, add and read on the partial sum memory, one item per cycle
// while the result queue has room, with a one-entry bypass for back-to-back
// updates of the same index, and keeps the sticky overflow flag.
// ----------------------------------------------------------------------------
`include "factor_sum_out_variable_macros.svh"

module fsov_back #(
  parameter int TABLE_DEPTH = 4096,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mq_empty,
  input  fsov_pkg::mid_item_t mq_item,
  output logic                mq_pop,
  input  logic                oq_full,
  output logic                oq_push,
  output fsov_pkg::out_item_t oq_item
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int VW = VALUE_WIDTH;

  logic [VW-1:0]       mem [TABLE_DEPTH];
  logic [VW-1:0]       rd_r;
  logic [VW-1:0]       byp_r;
  logic                byp_v_r;
  logic                y_v_r;
  fsov_pkg::mid_item_t y_r;
  logic                flag_r;
  logic                b_adv;
  logic                is_acc;
  logic [VW-1:0]       old_val;
  logic [VW-1:0]       add_val;
  logic [VW:0]         sum_w;
  logic [VW-1:0]       sum;
  logic                sat;
  logic                flag_new;

  assign b_adv   = !y_v_r || !oq_full;
  assign mq_pop  = b_adv && !mq_empty;
  assign oq_push = y_v_r && !oq_full;
  assign is_acc  = (y_r.cmd == fsov_pkg::CMD_ACCUM);
  assign old_val = byp_v_r ? byp_r : rd_r;
  assign add_val = VW'(y_r.value);
  assign sum_w   = {1'b0, old_val} + {1'b0, add_val};

  always_comb begin
    sat = 1'b0;
    if (y_r.wr_new) begin
      sum = add_val;
    end else if (sum_w[VW]) begin
      sum = '1;
      sat = 1'b1;
    end else begin
      sum = sum_w[VW-1:0];
    end
    flag_new = (y_r.first ? 1'b0 : flag_r) | sat;
  end

  always_comb begin
    oq_item.result_index = fsov_pkg::RINDEX_W'(y_r.idx);
    oq_item.result_value = fsov_pkg::ENTRY_W'(is_acc ? sum : old_val);
    oq_item.overflow     = is_acc ? flag_new : flag_r;
    oq_item.table_done   = is_acc && y_r.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_v_r   <= 1'b0;
      byp_v_r <= 1'b0;
      flag_r  <= 1'b0;
    end else begin
      if (b_adv) begin
        y_v_r   <= !mq_empty;
        byp_v_r <= oq_push && is_acc && (y_r.idx == mq_item.idx);
      end
      if (oq_push && is_acc) begin
        flag_r <= flag_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      y_r   <= mq_item;
      byp_r <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      rd_r <= mem[mq_item.idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push && is_acc) begin
      mem[y_r.idx[AW-1:0]] <= sum;
    end
  end

  `FSOV_ASSERT_NOW(a_byp_from_write, byp_v_r && $past(b_adv), $past(oq_push && is_acc))
  `FSOV_ASSERT_NOW(a_flag_clear_on_first, $fell(flag_r), $past(oq_push && y_r.first))
  `FSOV_ASSERT_NEXT(a_pop_lands_in_y, mq_pop, y_v_r)

endmodule

>>> rtl/factor_sum_out_variable.sv
// ----------------------------------------------------------------------------
// factor_sum_out_variable
// Streams the entries of a discrete factor table and sums one scope variable
// out of it into a partial sum memory; read commands return stored sums.
//
// Input queue: an item is taken on a clock edge with in_push high and in_full
// low. Each item is either a table entry (row-major, last variable fastest)
// or a read of one result index. Every item gives exactly one result.
// Result queue: the oldest result is on out_item while out_empty is low and
// is taken on an edge with out_pop high.
// Configuration: cfg_we writes register cfg_index from cfg_wdata at once;
// write only while no item is in flight.
// Throughput is one item per cycle while in_full stays low. The index
// pipeline has one Horner stage per scope position, at least three.
// Reset clears the digit counter, the overflow flag and all queues and sets
// the registers to one variable, cardinality one, variable absent. The sum
// memory is not cleared. When out_pop stays low the result queue fills, the
// store stage and the middle queue hold, and in_full rises.
// ----------------------------------------------------------------------------
module factor_sum_out_variable #(
  parameter int MAX_VARS    = 8,
  parameter int TABLE_DEPTH = 4096,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  fsov_pkg::in_item_t                  in_item,
  output logic                                out_empty,
  input  logic                                out_pop,
  output fsov_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [fsov_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsov_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  fsov_pkg::cfg_t      cfg_r;
  logic                mq_push;
  logic                mq_full;
  logic                mq_pop;
  logic                mq_empty;
  fsov_pkg::mid_item_t mq_in;
  fsov_pkg::mid_item_t mq_out;
  logic                oq_push;
  logic                oq_full;
  fsov_pkg::out_item_t oq_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_vars <= 4'd1;
      cfg_r.cards    <= '0;
      cfg_r.sum_pos  <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        fsov_pkg::REG_NUM_VARS: cfg_r.num_vars <= cfg_wdata[3:0];
        fsov_pkg::REG_CARDS:    cfg_r.cards    <= cfg_wdata[31:0];
        fsov_pkg::REG_SUM_POS:  cfg_r.sum_pos  <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  fsov_front #(
    .MAX_VARS    (MAX_VARS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .mq_push (mq_push),
    .mq_item (mq_in),
    .mq_full (mq_full)
  );

  fsov_fifo #(
    .item_t (fsov_pkg::mid_item_t),
    .DEPTH  (2)
  ) u_mid_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (mq_push),
    .full     (mq_full),
    .data_in  (mq_in),
    .pop      (mq_pop),
    .empty    (mq_empty),
    .data_out (mq_out)
  );

  fsov_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mq_empty (mq_empty),
    .mq_item  (mq_out),
    .mq_pop   (mq_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_item  (oq_in)
  );

  fsov_fifo #(
    .item_t (fsov_pkg::out_item_t),
    .DEPTH  (2)
  ) u_out_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (oq_push),
    .full     (oq_full),
    .data_in  (oq_in),
    .pop      (out_pop),
    .empty    (out_empty),
    .data_out (out_item)
  );

endmodule

>>> test/factor_sum_out_variable_tb.sv
// ----------------------------------------------------------------------------
// factor_sum_out_variable_tb
// Self-checking testbench for the factor sum-out block. A shadow of the digit
// counter, the partial sum store and the overflow flag predicts every result.
// Directed tables cover the reset settings, scope clamping, summing out a
// middle variable, saturation and its clearing, and index wrap after a
// mid-table change of settings. A long receiver hold fills the block, and
// random tables with interleaved reads and random idling on both queue
// sides follow.
// ----------------------------------------------------------------------------
module factor_sum_out_variable_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_VARS    = 8;
  localparam int TABLE_DEPTH = 4096;
  localparam int LATENCY     = MAX_VARS + 3;
  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 1700;

  localparam logic [fsov_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                            clk;
  logic                            rst_n;
  logic                            in_push;
  logic                            in_full;
  fsov_pkg::in_item_t              in_item;
  logic                            out_empty;
  logic                            out_pop;
  fsov_pkg::out_item_t             out_item;
  logic                            cfg_we;
  logic [fsov_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fsov_pkg::CFG_DATA_W-1:0] cfg_wdata;

  logic [3:0]                   reg_num_vars;
  logic [31:0]                  reg_cards;
  logic [3:0]                   reg_sum_pos;
  logic [fsov_pkg::DIGIT_W-1:0] digit_ctr [MAX_VARS];
  logic [fsov_pkg::ENTRY_W-1:0] sum_store [TABLE_DEPTH];
  bit                           sum_written [TABLE_DEPTH];
  bit                           sat_flag;
  int                           written_list [$];

  fsov_pkg::out_item_t pending_sums [$];
  int                  fail_count;
  int                  sent_count;
  bit                  hold_req;
  bit                  no_idle;

  factor_sum_out_variable dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int active_vars();
    if (reg_num_vars == 0) return 1;
    if (reg_num_vars > MAX_VARS) return MAX_VARS;
    return int'(reg_num_vars);
  endfunction

  function automatic int card_field(input int i);
    return int'(reg_cards[4*i +: 4]);
  endfunction

  function automatic fsov_pkg::out_item_t marginal_step(input fsov_pkg::in_item_t it);
    fsov_pkg::out_item_t          r;
    int                           n;
    int                           pos;
    bit                           absent;
    bit                           first;
    longint unsigned              idx;
    longint unsigned              stride;
    logic [fsov_pkg::ENTRY_W:0]   wide;
    logic [fsov_pkg::ENTRY_W-1:0] old;
    logic [fsov_pkg::ENTRY_W-1:0] total;
    n = active_vars();
    if (it.cmd == fsov_pkg::CMD_READ) begin
      r.result_index = it.read_index;
      r.result_value = sum_written[it.read_index] ? sum_store[it.read_index] : '0;
      r.overflow     = sat_flag;
      r.table_done   = 1'b0;
      return r;
    end
    absent = (reg_sum_pos >= n);
    pos    = int'(reg_sum_pos);
    first  = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (digit_ctr[i] != 0) first = 1'b0;
    end
    if (first) sat_flag = 1'b0;
    idx    = 0;
    stride = 1;
    for (int i = n - 1; i >= 0; i--) begin
      if (!absent && i == pos) continue;
      idx    += digit_ctr[i] * stride;
      stride *= longint'(card_field(i)) + 1;
    end
    idx = idx % TABLE_DEPTH;
    if (absent || digit_ctr[pos] == 0) begin
      total = it.entry_value;
    end else begin
      old  = sum_written[idx] ? sum_store[idx] : '0;
      wide = {1'b0, old} + {1'b0, it.entry_value};
      if (wide[fsov_pkg::ENTRY_W]) begin
        total    = '1;
        sat_flag = 1'b1;
      end else begin
        total = wide[fsov_pkg::ENTRY_W-1:0];
      end
    end
    sum_store[idx] = total;
    if (!sum_written[idx]) begin
      sum_written[idx] = 1'b1;
      written_list.insert(written_list.size(), int'(idx));
    end
    r.table_done = 1'b1;
    for (int i = n - 1; i >= 0; i--) begin
      if (digit_ctr[i] < card_field(i)) begin
        digit_ctr[i]++;
        r.table_done = 1'b0;
        break;
      end
      digit_ctr[i] = '0;
    end
    r.result_index = idx[fsov_pkg::RINDEX_W-1:0];
    r.result_value = total;
    r.overflow     = sat_flag;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [fsov_pkg::ENTRY_W-1:0] rand_entry();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 6) return $urandom_range(0, 255);
    if (r < 9) return $urandom | 32'hF000_0000;
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  task automatic wait_drained();
    in_push <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic configure(input logic [3:0] nv, input logic [31:0] cards,
                           input logic [3:0] pos, input bit poke_unused);
    logic [fsov_pkg::CFG_DATA_W-1:0] junk;
    junk = $urandom;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= fsov_pkg::REG_NUM_VARS;
    cfg_wdata <= {junk[31:4], nv};
    @(posedge clk);
    cfg_index <= fsov_pkg::REG_CARDS;
    cfg_wdata <= cards;
    @(posedge clk);
    cfg_index <= fsov_pkg::REG_SUM_POS;
    cfg_wdata <= {junk[27:0], pos};
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_we       <= 1'b0;
    reg_num_vars = nv;
    reg_cards    = cards;
    reg_sum_pos  = pos;
  endtask

  task automatic send_item(input fsov_pkg::in_item_t it, output fsov_pkg::out_item_t pred);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    pred = marginal_step(it);
    pending_sums.insert(pending_sums.size(), pred);
    sent_count++;
  endtask

  task automatic send_entry(input logic [fsov_pkg::ENTRY_W-1:0] value, output bit done);
    fsov_pkg::in_item_t  it;
    fsov_pkg::out_item_t pred;
    it.cmd         = fsov_pkg::CMD_ACCUM;
    it.entry_value = value;
    it.read_index  = fsov_pkg::RINDEX_W'($urandom);
    send_item(it, pred);
    done = pred.table_done;
  endtask

  task automatic send_read(input logic [fsov_pkg::RINDEX_W-1:0] idx);
    fsov_pkg::in_item_t  it;
    fsov_pkg::out_item_t pred;
    it.cmd         = fsov_pkg::CMD_READ;
    it.entry_value = $urandom;
    it.read_index  = idx;
    send_item(it, pred);
  endtask

  task automatic check_result(input fsov_pkg::out_item_t got);
    fsov_pkg::out_item_t want;
    if (pending_sums.size() == 0) begin
      $error("unexpected item: index %0d value %h", got.result_index, got.result_value);
      fail_count++;
      return;
    end
    want = pending_sums.pop_front();
    if (got.result_index !== want.result_index) begin
      $error("result_index: expected %0d, got %0d", want.result_index, got.result_index);
      fail_count++;
    end
    if (got.result_value !== want.result_value) begin
      $error("result_value: expected %h, got %h", want.result_value, got.result_value);
      fail_count++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
      fail_count++;
    end
    if (got.table_done !== want.table_done) begin
      $error("table_done: expected %0b, got %0b", want.table_done, got.table_done);
      fail_count++;
    end
  endtask

  task automatic test_after_reset();
    bit done;
    send_entry(32'hFFFF_FFFF, done);
    send_entry(32'h0000_0000, done);
    send_read(12'd0);
  endtask

  task automatic test_scope_clamp();
    bit done;
    configure(4'd0, 32'hFFFF_FFF1, 4'd15, 1'b0);
    done = 1'b0;
    while (!done) send_entry(rand_entry(), done);
  endtask

  task automatic test_sum_middle();
    bit done;
    configure(4'd3, 32'h0000_0111, 4'd1, 1'b0);
    done = 1'b0;
    while (!done) send_entry(rand_entry(), done);
    send_read(12'd3);
  endtask

  task automatic test_saturation();
    bit done;
    configure(4'd1, 32'h0000_0002, 4'd0, 1'b0);
    send_entry(32'hFFFF_FFFF, done);
    send_entry(32'h0000_0001, done);
    send_entry(32'h0000_0000, done);
    send_read(12'd0);
    send_entry(32'hFFFF_0000, done);
    send_entry(32'h0000_FFFF, done);
    send_entry(32'h0000_0000, done);
  endtask

  task automatic test_index_wrap();
    bit done;
    configure(4'd1, 32'h0000_0001, 4'd8, 1'b1);
    send_entry(rand_entry(), done);
    configure(4'd6, 32'h00C6_4221, 4'd8, 1'b0);
    send_entry(rand_entry(), done);
    send_entry(rand_entry(), done);
    send_read(12'hFFF);
    configure(4'd8, 32'h0000_0000, 4'd8, 1'b0);
    send_entry(rand_entry(), done);
  endtask

  task automatic test_backpressure();
    bit done;
    configure(4'd2, 32'h0000_003F, 4'd1, 1'b0);
    no_idle  = 1'b1;
    hold_req = 1'b1;
    done     = 1'b0;
    while (!done) send_entry(rand_entry(), done);
    no_idle = 1'b0;
  endtask

  task automatic test_random_tables();
    logic [3:0]  nv;
    logic [3:0]  pos;
    logic [31:0] cards;
    int          n;
    int          budget;
    int          prod;
    int          maxc;
    int          c;
    int          rot;
    int          vi;
    int          r;
    int          tables;
    bit          done;
    while (sent_count < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        nv = ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(9, 15));
      end else begin
        nv = 4'($urandom_range(1, 8));
      end
      n      = (nv == 0) ? 1 : ((nv > MAX_VARS) ? MAX_VARS : int'(nv));
      budget = ($urandom_range(0, 19) == 0) ? 256 : 40;
      cards  = $urandom;
      prod   = 1;
      rot    = $urandom_range(0, n - 1);
      for (int k = 0; k < n; k++) begin
        vi   = (k + rot) % n;
        maxc = budget / prod;
        if (maxc > 16) maxc = 16;
        c    = $urandom_range(1, maxc);
        prod = prod * c;
        cards[4*vi +: 4] = 4'(c - 1);
      end
      r = $urandom_range(0, 99);
      if (r < 70) pos = 4'($urandom_range(0, n - 1));
      else if (r < 85) pos = 4'd8;
      else pos = 4'($urandom_range(0, 15));
      configure(nv, cards, pos, $urandom_range(0, 7) == 0);
      no_idle = ($urandom_range(0, 4) == 0);
      tables  = $urandom_range(1, 3);
      repeat (tables) begin
        done = 1'b0;
        while (!done) begin
          if (written_list.size() > 0 && $urandom_range(0, 9) == 0) begin
            send_read(12'(written_list[$urandom_range(0, written_list.size() - 1)]));
          end
          send_entry(rand_entry(), done);
        end
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) check_result(out_item);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !no_idle) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_push   <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    fail_count   = 0;
    sent_count   = 0;
    hold_req     = 1'b0;
    no_idle      = 1'b0;
    reg_num_vars = 4'd1;
    reg_cards    = '0;
    reg_sum_pos  = 4'd8;
    sat_flag     = 1'b0;
    for (int i = 0; i < MAX_VARS; i++) digit_ctr[i] = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) sum_written[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_scope_clamp();
    test_sum_middle();
    test_saturation();
    test_index_wrap();
    test_backpressure();
    test_random_tables();

    wait_drained();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
